>>> sv/psubc_pkg.sv
// ----------------------------------------------------------------------------
// Swing-up and balance controller package
// Shared types, constants and helper functions.
// ----------------------------------------------------------------------------
package psubc_pkg;

    localparam int COUNTS_PER_TURN_DEF = 4096;
    localparam int POSITION_BITS_DEF   = 24;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 24;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [CFG_IDX_W-1:0] REG_VMAX       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PANG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PRATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_AANG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ARATE = 3'd4;

    typedef struct packed {
        logic       op;
        logic       arm_valid;
        logic [1:0] arm_ab;
        logic       pend_valid;
        logic [1:0] pend_ab;
        logic       z_arm;
        logic       z_pend;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LAW,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } back_state_t;

    function automatic logic [1:0] gray_index(input logic [1:0] code);
        gray_index = {code[1], code[1] ^ code[0]};
    endfunction

endpackage

>>> sv/psubc_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts beats and queues them, samples and ticks alike, for the back end.
// ----------------------------------------------------------------------------
module psubc_front
    import psubc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  item_t in_item,
    output logic  q_valid,
    input  logic  q_pop,
    output item_t q_item
);

    item_t       mem_reg [QUEUE_DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;

    assign in_stall = (count_reg == 2'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = (q_pop && q_valid) ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop && q_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(QUEUE_DEPTH)) else $error("queue overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'(QUEUE_DEPTH)) |-> !push) else $error("push when full");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("count slip");

endmodule

>>> sv/psubc_back.sv
// ----------------------------------------------------------------------------
// Back end
// Runs the encoder counters and, on each tick, the control law and divider.
// ----------------------------------------------------------------------------
module psubc_back
    import psubc_pkg::*;
#(
    parameter int COUNTS_PER_TURN = COUNTS_PER_TURN_DEF,
    parameter int POSITION_BITS   = POSITION_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  item_t                 q_item,
    input  logic [15:0]           vmax_volts,
    input  logic signed [23:0]    gain_pend_angle,
    input  logic signed [23:0]    gain_pend_rate,
    input  logic signed [23:0]    gain_arm_angle,
    input  logic signed [23:0]    gain_arm_rate,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [15:0]           duty,
    output logic                  drive_positive
);

    localparam int PB = POSITION_BITS;
    localparam int TB = $clog2(COUNTS_PER_TURN);
    localparam int HALF = COUNTS_PER_TURN / 2;
    localparam longint CATCH = (longint'(COUNTS_PER_TURN) * 716197) / 10000000;
    localparam longint SOFT = (longint'(COUNTS_PER_TURN) * 477465) / 100000000;
    localparam longint DBAND = (longint'(COUNTS_PER_TURN) * 795775 + 64'd9999999999)
        / 64'd10000000000;
    localparam int CGAIN = 4941299 / COUNTS_PER_TURN;
    localparam int UW = 64;

    back_state_t state_reg, state_next;
    logic [PB-1:0] arm_pos_reg, arm_pos_next, pend_pos_reg, pend_pos_next;
    logic [PB-1:0] arm_prior_reg, pend_prior_reg;
    logic [1:0]    arm_code_reg, arm_code_next, pend_code_reg, pend_code_next;
    logic signed [PB-1:0] arm_reg, darm_reg, dpend_reg;
    logic signed [TB:0]   err_reg;
    logic [2:0]    mcnt_reg;
    logic signed [UW-1:0] acc_reg, u_reg;
    logic [26:0]   amag_reg;
    logic          aneg_reg;
    logic [26:0]   swing_pre_reg;
    logic signed [PB+15:0] carm_reg;
    logic [25:0]   rem_reg;
    logic [16:0]   shift_reg;
    logic [16:0]   quo_reg;
    logic [4:0]    dcnt_reg;
    logic [15:0]   duty_reg;
    logic          pos_reg, ov_reg;

    logic [PB-1:0] arm_snap, pend_snap;
    logic signed [UW-1:0] prod, vq, uc;
    logic signed [23:0]   mul_a;
    logic signed [PB-1:0] mul_b;
    logic signed [PB+23:0] mul_p;
    logic signed [PB-1:0] pend_s;
    logic [TB-1:0] ewrap;
    logic signed [TB:0] err_c, err_abs;
    logic [UW-1:0] acc_abs, umag;
    logic [PB-1:0] dpend_abs;
    logic          swing_neg;
    logic [29:0]   t7;
    logic [61:0]   q10_full;
    logic [26:0]   q10;
    logic [58:0]   q5_full;
    logic [24:0]   swing_q;
    logic [25:0]   vq_d, trial;
    logic q_take;

    function automatic logic [PB-1:0] step_pos(input logic [PB-1:0] p,
        input logic [1:0] last, input logic [1:0] code);
        logic [1:0] s;
        s = gray_index(last) - gray_index(code);
        if (s == 2'd1) step_pos = p + PB'(1);
        else if (s == 2'd3) step_pos = p - PB'(1);
        else step_pos = p;
    endfunction

    function automatic logic [PB-1:0] snap(input logic [PB-1:0] p);
        logic [PB-1:0] a, r;
        logic neg;
        neg = p[PB-1];
        a = neg ? -p : p;
        r = ((a + PB'(HALF)) >> TB) << TB;
        snap = neg ? -r : r;
    endfunction

    assign arm_snap  = q_item.z_arm ? snap(arm_pos_reg) : arm_pos_reg;
    assign pend_snap = q_item.z_pend ? snap(pend_pos_reg) : pend_pos_reg;
    assign q_take    = (state_reg == ST_IDLE) && q_valid;
    assign q_pop     = q_take;
    assign pend_s    = pend_snap;
    assign ewrap     = TB'(pend_s - PB'(HALF));
    assign err_c     = (ewrap > TB'(HALF)) ? $signed({1'b1, ewrap}) : $signed({1'b0, ewrap});
    assign vq        = $signed({40'd0, vmax_volts, 8'd0});
    assign vq_d      = {2'b00, vmax_volts, 8'd0};

    assign err_abs   = (err_reg < 0) ? -err_reg : err_reg;
    assign acc_abs   = acc_reg[UW-1] ? -acc_reg : acc_reg;
    assign dpend_abs = dpend_reg[PB-1] ? -dpend_reg : dpend_reg;
    assign swing_neg = (dpend_abs < PB'(DBAND)) ? (arm_reg > 0) : (dpend_reg > 0);

    // Both divisions by a constant use a reciprocal multiply that is exact
    // for dividends below 2^32.
    assign t7        = 30'({amag_reg, 3'd0}) - 30'(amag_reg);
    assign q10_full  = t7 * 32'hCCCCCCCD;
    assign q10       = q10_full[61:35];
    assign q5_full   = swing_pre_reg * 32'hCCCCCCCD;
    assign swing_q   = q5_full[58:34];

    assign umag      = (uc < 0) ? -uc : uc;
    assign trial     = {rem_reg[24:0], shift_reg[16]};

    always_comb
    begin
        case (mcnt_reg)
            3'd0:
            begin
                mul_a = gain_pend_angle;
                mul_b = PB'(err_reg);
            end
            3'd1:
            begin
                mul_a = gain_pend_rate;
                mul_b = dpend_reg;
            end
            3'd2:
            begin
                mul_a = gain_arm_angle;
                mul_b = arm_reg;
            end
            default:
            begin
                mul_a = gain_arm_rate;
                mul_b = darm_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign prod  = UW'(mul_p);

    always_comb
    begin
        uc = u_reg;
        if (u_reg > vq) uc = vq;
        if (u_reg < -vq) uc = -vq;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (q_valid && q_item.op) state_next = ST_MUL;
            ST_MUL:  if (mcnt_reg == 3'd4) state_next = ST_LAW;
            ST_LAW:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_DIV;
            ST_DIV:  if (dcnt_reg == 5'd17) state_next = ST_OUT;
            ST_OUT:  if (!out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        arm_pos_next  = arm_pos_reg;
        pend_pos_next = pend_pos_reg;
        arm_code_next = arm_code_reg;
        pend_code_next = pend_code_reg;
        if (q_take && !q_item.op)
        begin
            if (q_item.arm_valid)
            begin
                arm_pos_next  = step_pos(arm_pos_reg, arm_code_reg, q_item.arm_ab);
                arm_code_next = q_item.arm_ab;
            end
            if (q_item.pend_valid)
            begin
                pend_pos_next  = step_pos(pend_pos_reg, pend_code_reg, q_item.pend_ab);
                pend_code_next = q_item.pend_ab;
            end
        end
        else if (q_take)
        begin
            arm_pos_next  = arm_snap;
            pend_pos_next = pend_snap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            arm_pos_reg    <= '0;
            pend_pos_reg   <= '0;
            arm_prior_reg  <= '0;
            pend_prior_reg <= '0;
            arm_code_reg   <= 2'd0;
            pend_code_reg  <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            arm_pos_reg   <= arm_pos_next;
            pend_pos_reg  <= pend_pos_next;
            arm_code_reg  <= arm_code_next;
            pend_code_reg <= pend_code_next;
            if (q_take && q_item.op)
            begin
                arm_prior_reg  <= arm_snap;
                pend_prior_reg <= pend_snap;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                arm_reg   <= arm_snap;
                darm_reg  <= arm_snap - arm_prior_reg;
                dpend_reg <= pend_snap - pend_prior_reg;
                err_reg   <= err_c;
                mcnt_reg  <= 3'd0;
                acc_reg   <= '0;
            end
            ST_MUL:
            begin
                if (mcnt_reg != 3'd4)
                begin
                    acc_reg  <= acc_reg + prod;
                    mcnt_reg <= mcnt_reg + 3'd1;
                end
                else
                begin
                    // Any magnitude above 2^26 saturates to Vmax after scaling.
                    amag_reg      <= (acc_abs > UW'(27'h4000000)) ? 27'h4000000
                                                                  : acc_abs[26:0];
                    aneg_reg      <= acc_reg[UW-1];
                    swing_pre_reg <= 27'({vmax_volts, 10'd0}) + 27'({vmax_volts, 6'd0})
                                     + 27'd2;
                    carm_reg      <= $signed(17'(CGAIN)) * arm_reg;
                end
            end
            ST_LAW:
            begin
                if (err_abs <= (TB+1)'(CATCH))
                begin
                    if (err_abs <= (TB+1)'(SOFT))
                        u_reg <= aneg_reg ? -UW'(q10) : UW'(q10);
                    else
                        u_reg <= acc_reg;
                end
                else
                begin
                    u_reg <= (swing_neg ? -UW'(swing_q) : UW'(swing_q)) - UW'(carm_reg);
                end
            end
            ST_SUM:
            begin
                pos_reg   <= (uc >= 0);
                rem_reg   <= {1'b0, umag[25:1]};
                shift_reg <= {umag[0], 16'd0};
                quo_reg   <= '0;
                dcnt_reg  <= 5'd0;
            end
            ST_DIV:
            begin
                if (dcnt_reg != 5'd17)
                begin
                    if (trial >= vq_d)
                    begin
                        rem_reg <= trial - vq_d;
                        quo_reg <= {quo_reg[15:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial;
                        quo_reg <= {quo_reg[15:0], 1'b0};
                    end
                    shift_reg <= {shift_reg[15:0], 1'b0};
                    dcnt_reg  <= dcnt_reg + 5'd1;
                end
                else
                begin
                    duty_reg <= (vq == 0) ? 16'd0 : (quo_reg[16] ? 16'hFFFF : quo_reg[15:0]);
                    ov_reg   <= (vq == 0);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid      = (state_reg == ST_OUT);
    assign duty           = duty_reg;
    assign drive_positive = ov_reg | pos_reg;

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == ST_IDLE) else $error("pop while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid) else $error("result dropped");
    a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
        (q_take && q_item.op) |=> state_reg == ST_MUL) else $error("tick lost");

endmodule

>>> sv/pendulum_swing_up_balance_controller_top.sv
// ----------------------------------------------------------------------------
// Pendulum swing-up and balance controller, top level
// Sample beats step two quadrature counters. A tick beat runs four
// multiply-accumulates, a scaling step and a 17-step restoring divider in
// the back end. A two-entry queue separates acceptance from the back end.
// Configuration is a plain write port.
// ----------------------------------------------------------------------------
module pendulum_swing_up_balance_controller_top
    import psubc_pkg::*;
#(
    parameter int COUNTS_PER_TURN = COUNTS_PER_TURN_DEF,
    parameter int POSITION_BITS   = POSITION_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic                  arm_valid,
    input  logic [1:0]            arm_ab,
    input  logic                  pend_valid,
    input  logic [1:0]            pend_ab,
    input  logic                  z_arm,
    input  logic                  z_pend,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [15:0]           duty,
    output logic                  drive_positive
);

    logic [15:0]        vmax_reg;
    logic signed [23:0] gpa_reg, gpr_reg, gaa_reg, gar_reg;
    item_t in_item, q_item;
    logic  q_valid, q_pop;

    assign in_item = '{op: op, arm_valid: arm_valid, arm_ab: arm_ab,
                       pend_valid: pend_valid, pend_ab: pend_ab,
                       z_arm: z_arm, z_pend: z_pend};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vmax_reg <= 16'd3072;
            gpa_reg  <= -24'sd10155;
            gpr_reg  <= -24'sd1247590;
            gaa_reg  <= 24'sd1005;
            gar_reg  <= 24'sd736894;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_VMAX:       vmax_reg <= cfg_data[15:0];
                REG_GAIN_PANG:  gpa_reg  <= cfg_data;
                REG_GAIN_PRATE: gpr_reg  <= cfg_data;
                REG_GAIN_AANG:  gaa_reg  <= cfg_data;
                REG_GAIN_ARATE: gar_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    psubc_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
    );

    psubc_back #(
        .COUNTS_PER_TURN(COUNTS_PER_TURN), .POSITION_BITS(POSITION_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop),
        .q_item(q_item), .vmax_volts(vmax_reg), .gain_pend_angle(gpa_reg),
        .gain_pend_rate(gpr_reg), .gain_arm_angle(gaa_reg),
        .gain_arm_rate(gar_reg), .out_valid(out_valid), .out_stall(out_stall),
        .duty(duty), .drive_positive(drive_positive)
    );

endmodule
